// File: hdl/mbrf_pkg.sv
`default_nettype none
package mbrf_pkg;

  localparam int NCH = 5;
  localparam int SW  = 24;
  localparam int CW  = 32;
  localparam int BWW = 17;

  localparam logic [2:0] CFG_COEF_PM1  = 3'd0;
  localparam logic [2:0] CFG_COEF_PM2  = 3'd1;
  localparam logic [2:0] CFG_COEF_PM3  = 3'd2;
  localparam logic [2:0] CFG_COEF_HUM  = 3'd3;
  localparam logic [2:0] CFG_COEF_TEMP = 3'd4;
  localparam logic [2:0] CFG_OFFSET    = 3'd5;
  localparam logic [2:0] CFG_WEIGHT    = 3'd6;

  typedef struct packed {
    logic signed [SW-1:0] pm1_sample;
    logic signed [SW-1:0] pm2_sample;
    logic signed [SW-1:0] pm3_sample;
    logic signed [SW-1:0] temperature_sample;
    logic signed [SW-1:0] humidity_sample;
    logic                 env_valid;
  } in_beat_t;

  typedef struct packed {
    logic signed [SW-1:0] pm1_filtered;
    logic signed [SW-1:0] pm2_filtered;
    logic signed [SW-1:0] pm3_filtered;
    logic signed [SW-1:0] temperature_filtered;
    logic signed [SW-1:0] humidity_filtered;
    logic signed [SW-1:0] pm_estimate;
  } out_beat_t;

endpackage
`default_nettype wire

// File: hdl/median_blend_regression_filter_core.sv
`default_nettype none
// Median blend regression filter.
// Input beats (in_valid/in_stall) carry five channel samples and env_valid.
// Every third beat closes a median per channel; the first four medians only
// fill the history, after which each third beat yields one output beat
// (out_valid/out_stall) with five blended values and a saturated estimate.
// After the closing input beat the sequencer blends, runs the regression and
// then raises out_valid. Input takes one beat per cycle while collecting; a
// closing beat holds the input while the shared regression multiplier walks
// six terms, and then until the output beat is taken. Config via
// cfg_we/cfg_index/cfg_data, only while idle; not enforced by the block.
// Reset (synchronous rst_n low) restores register defaults, clears slots,
// slot counter and history fill. A stalled output holds its beat; the block
// accepts no new beat until that beat is taken.
module median_blend_regression_filter_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire mbrf_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mbrf_pkg::out_beat_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  logic signed [31:0] coef_r [6];
  logic [16:0] weight_r;
  logic [1:0] slot_r;
  logic [2:0] fill_r;
  logic [3:0] step_r;
  logic busy_r, out_valid_r;
  logic acc;
  logic signed [23:0] bl [5];
  logic signed [23:0] est;
  logic signed [31:0] mcoef;
  logic signed [23:0] mval;
  logic [2:0] term;

  assign in_stall = busy_r || out_valid_r;
  assign acc = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // advance config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= 32'sd42608; coef_r[1] <= 32'sd391; coef_r[2] <= 32'sd57745;
      coef_r[3] <= 32'sd1642715; coef_r[4] <= -32'sd777040;
      coef_r[5] <= 32'sd451470; weight_r <= 17'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbrf_pkg::CFG_COEF_PM1:  coef_r[0] <= cfg_data;
        mbrf_pkg::CFG_COEF_PM2:  coef_r[1] <= cfg_data;
        mbrf_pkg::CFG_COEF_PM3:  coef_r[2] <= cfg_data;
        mbrf_pkg::CFG_COEF_HUM:  coef_r[3] <= cfg_data;
        mbrf_pkg::CFG_COEF_TEMP: coef_r[4] <= cfg_data;
        mbrf_pkg::CFG_OFFSET:    coef_r[5] <= cfg_data;
        mbrf_pkg::CFG_WEIGHT:    weight_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic close;
  assign close = acc && (slot_r == 2'd2);

  // sequencer: step 1 blends, steps 2..7 feed products, step 8 adds the last,
  // step 10 loads the output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0; fill_r <= '0; step_r <= '0; busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (acc) slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
      if (close) begin
        if (fill_r != 3'd4) fill_r <= fill_r + 3'd1;
        else begin busy_r <= 1'b1; step_r <= 4'd1; end
      end
      if (busy_r) begin
        if (step_r == 4'd10) begin busy_r <= 1'b0; out_valid_r <= 1'b1; end
        step_r <= step_r + 4'd1;
      end
    end
  end

  // mux the next regression term (humidity coef pairs with humidity lane)
  always_comb begin
    mcoef = coef_r[0]; mval = bl[0];
    case (step_r)
      4'd2: begin mcoef = coef_r[0]; mval = bl[0]; end
      4'd3: begin mcoef = coef_r[1]; mval = bl[1]; end
      4'd4: begin mcoef = coef_r[2]; mval = bl[2]; end
      4'd5: begin mcoef = coef_r[3]; mval = bl[4]; end
      4'd6: begin mcoef = coef_r[4]; mval = bl[3]; end
      4'd7: begin mcoef = coef_r[5]; mval = 24'sd256; end
      default: ;
    endcase
    term = (step_r >= 4'd3 && step_r <= 4'd8) ? 3'd1 : 3'd0;
  end

  logic signed [23:0] smp [5];
  assign smp[0] = in_data.pm1_sample;
  assign smp[1] = in_data.pm2_sample;
  assign smp[2] = in_data.pm3_sample;
  assign smp[3] = in_data.temperature_sample;
  assign smp[4] = in_data.humidity_sample;

  for (genvar g = 0; g < 5; g++) begin : g_lane
    mbrf_lane u_lane (
      .clk(clk), .rst_n(rst_n),
      .wr_en(acc && (g < 3 || in_data.env_valid)),
      .wr_slot(slot_r), .wr_data(smp[g]),
      .med_go(close), .hist_full(fill_r == 3'd4), .fill_idx(fill_r[1:0]),
      .weight(weight_r), .blend_go(busy_r && step_r == 4'd1),
      .blended(bl[g])
    );
  end

  mbrf_merge u_merge (
    .clk(clk), .start(step_r == 4'd2 && busy_r), .term(term),
    .coef(mcoef), .val(mval), .est(est)
  );

  always_ff @(posedge clk) begin
    if (busy_r && step_r == 4'd10) begin
      out_data.pm1_filtered <= bl[0];
      out_data.pm2_filtered <= bl[1];
      out_data.pm3_filtered <= bl[2];
      out_data.temperature_filtered <= bl[3];
      out_data.humidity_filtered <= bl[4];
      out_data.pm_estimate <= est;
    end
  end
endmodule
`default_nettype wire

// File: hdl/mbrf_lane.sv
`default_nettype none
// One channel: median of three slots, history of four medians, blend.
module mbrf_lane (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [1:0]                    wr_slot,
  input  wire logic signed [mbrf_pkg::SW-1:0] wr_data,
  input  wire logic                          med_go,
  input  wire logic                          hist_full,
  input  wire logic [1:0]                    fill_idx,
  input  wire logic [mbrf_pkg::BWW-1:0]      weight,
  input  wire logic                          blend_go,
  output logic signed [mbrf_pkg::SW-1:0]     blended
);
  localparam int SWX = 59;
  logic signed [mbrf_pkg::SW-1:0] slot_r [3];
  logic signed [mbrf_pkg::SW-1:0] hist_r [4];
  logic signed [mbrf_pkg::SW-1:0] med_r;
  logic signed [mbrf_pkg::SW+1:0] sum_r;
  logic signed [mbrf_pkg::SW-1:0] a, b, c, lo, mid, hi;
  logic signed [mbrf_pkg::SW+1:0] sum_nxt;
  logic signed [58:0] num;
  logic [16:0] w;
  logic signed [18:0] ws, wr;
  logic signed [SWX-1:0] blended_nxt;

  always_comb begin
    a = slot_r[0]; b = slot_r[1]; c = slot_r[2];
    if (wr_en) begin
      if (wr_slot == 2'd2) c = wr_data;
    end
    // three-element sorting network
    lo = (a < b) ? a : b; hi = (a < b) ? b : a;
    mid = (hi < c) ? hi : ((lo < c) ? c : lo);
    if (c < lo) begin mid = lo; end
    sum_nxt = 26'(hist_r[0]) + 26'(hist_r[1]) + 26'(hist_r[2]) + 26'(hist_r[3]);
    w = (weight > 17'd65536) ? 17'd65536 : weight;
    ws = $signed({2'b0, w});
    wr = 19'sd65536 - ws;
    // divide by 4 * 65536, round to nearest with ties upward
    num = 59'(med_r) * 59'(ws) * 59'sd4 + 59'(sum_r) * 59'(wr) + 59'sd131072;
    blended_nxt = num >>> 18;
  end

  logic signed [mbrf_pkg::SW-1:0] smin, smax;
  always_comb begin
    smin = (lo < c) ? lo : c;
    smax = (hi > c) ? hi : c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r[0] <= '0; slot_r[1] <= '0; slot_r[2] <= '0;
    end else if (med_go) begin
      // leave slots ascending, as the sort would
      slot_r[0] <= smin; slot_r[1] <= mid; slot_r[2] <= smax;
    end else if (wr_en) begin
      slot_r[wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (med_go) begin
      med_r <= mid;
      sum_r <= sum_nxt;
      if (!hist_full) hist_r[fill_idx] <= mid;
      else begin
        hist_r[0] <= hist_r[1]; hist_r[1] <= hist_r[2];
        hist_r[2] <= hist_r[3]; hist_r[3] <= mid;
      end
    end
    if (blend_go) blended <= blended_nxt[mbrf_pkg::SW-1:0];
  end
endmodule
`default_nettype wire

// File: hdl/mbrf_merge.sv
`default_nettype none
// Regression over the blended lanes: one product a cycle into an accumulator.
module mbrf_merge (
  input  wire logic                          clk,
  input  wire logic                          start,
  input  wire logic [2:0]                    term,
  input  wire logic signed [mbrf_pkg::CW-1:0] coef,
  input  wire logic signed [mbrf_pkg::SW-1:0] val,
  output logic signed [mbrf_pkg::SW-1:0]     est
);
  logic signed [55:0] prod_r;
  logic signed [59:0] acc_r;
  logic signed [59:0] rnd;
  logic signed [43:0] q;
  always_ff @(posedge clk) begin
    prod_r <= coef * val;
    if (start) acc_r <= 60'sd32768;
    else if (term != 3'd0) acc_r <= acc_r + 60'(prod_r);
  end
  always_comb begin
    rnd = acc_r >>> 16;
    q = rnd[43:0];
    if (q > 44'sd8388607) est = 24'sh7FFFFF;
    else if (q < -44'sd8388608) est = 24'sh800000;
    else est = q[23:0];
  end
endmodule
`default_nettype wire
